### rtl/usf_pkg.sv
// Shared types, constants and byte classification functions for the URL span finder.
`timescale 1ns / 1ps
package usf_pkg;

   // Default offset limit; offsets are 16 bits, so the limit never exceeds 65535.
   localparam longint unsigned USF_MAX_TEXT = 64'd65535;
   localparam int unsigned USF_QDEPTH = 2;
   localparam int unsigned USF_POS_W = 16;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Separator match progress: none, ":", ":/", "://".
   localparam logic [1:0] SEP_NONE  = 2'd0;
   localparam logic [1:0] SEP_COLON = 2'd1;
   localparam logic [1:0] SEP_SLASH = 2'd2;
   localparam logic [1:0] SEP_FULL  = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } usf_req_type;

   typedef struct packed {
      logic [USF_POS_W-1:0] url_start;
      logic [USF_POS_W-1:0] url_stop;
      logic                 offsets_saturated;
   } usf_rsp_type;

   // Byte class handed from the front to the back.
   typedef struct packed {
      logic is_letter;
      logic is_url;
      logic is_colon;
      logic is_slash;
      logic last;
   } usf_cls_type;

   typedef struct packed {
      logic                 fire;
      logic                 last;
      logic                 inside_url;
      logic [1:0]           sep_stage;
      logic [USF_POS_W-1:0] pos;
   } usf_back_status_type;

   function automatic logic usf_is_letter(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         [8'h41:8'h5A], [8'h61:8'h7A]: r = 1'b1;
         default:                      r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic usf_is_url_char(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         [8'h41:8'h5A], [8'h61:8'h7A], [8'h27:8'h3B],
         8'h21, 8'h24, 8'h26, 8'h3D, 8'h3F, 8'h40, 8'h5F, 8'h7E: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### rtl/url_span_finder.sv
// Top level of the URL span finder: classifier, queue and scanner.
`timescale 1ns / 1ps
// Usage:
//   req channel: one text byte per item (req_item.text_byte) with
//   req_item.last_byte marking the final byte of a text. The block finds
//   "letters://" followed by a URL character and tracks the URL to its end.
//   rsp channel: one item per URL found, carrying the start offset, the
//   exclusive stop offset and a flag set once offsets have clamped at the
//   offset limit (MAX_TEXT, at most 65535).
//   Throughput: one byte per cycle without stalls; the classifier register, a
//   two-entry queue and the result register let either side stall alone.
//   Path: the byte that closes a URL passes the classifier register,
//   the queue and the result register before its result appears.
//   Stall: while a result waits with rsp_ready low it is held and the scanner stops;
//   the queue and classifier keep taking bytes until they fill, then
//   req_ready drops.
//   Reset: synchronous, active high; all scan state and queues clear, no
//   clearing pass. After a last byte the scan state clears as well.
module url_span_finder
   import usf_pkg::*;
#(
   parameter longint unsigned MAX_TEXT = USF_MAX_TEXT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  usf_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output usf_rsp_type rsp_item
);

   logic                f_valid, f_ready;
   usf_cls_type         f_item;
   logic                q_valid, q_ready;
   usf_cls_type         q_item;
   usf_back_status_type back_st;

   // Classify each byte and register it.
   usf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cls_valid (f_valid),
      .cls_ready (f_ready),
      .cls_item  (f_item)
   );

   // Decouple the classifier from the scanner.
   usf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Advance the scan state one byte per cycle while no held result blocks it, and hold results until taken.
   usf_back #(
      .MAX_TEXT (MAX_TEXT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (q_valid),
      .cls_ready (q_ready),
      .cls_item  (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .status    (back_st)
   );

   // Inside a URL no separator match may be in progress.
   a_inside_no_sep: assert property (@(posedge clock) disable iff (reset)
      back_st.inside_url |-> (back_st.sep_stage == SEP_NONE))
      else $error("separator match active inside URL");

   // The last byte of a text clears the scan state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (back_st.fire && back_st.last) |=> (back_st.pos == '0) && !back_st.inside_url)
      else $error("scan state not cleared after last byte");

   // A URL always ends past its start unless offsets clamped.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.url_stop > rsp_item.url_start) || rsp_item.offsets_saturated)
      else $error("URL stop not past start");

endmodule

### rtl/usf_front.sv
// Front stage: accepts text bytes and registers their character class.
`timescale 1ns / 1ps
module usf_front
   import usf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  usf_req_type req_item,
   output logic        cls_valid,
   input  logic        cls_ready,
   output usf_cls_type cls_item
);

   logic        valid_ff, valid_in;
   usf_cls_type cls_ff, cls_in;
   logic        take;

   assign req_ready = !valid_ff || cls_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      cls_in.is_letter = usf_is_letter(req_item.text_byte);
      cls_in.is_url    = usf_is_url_char(req_item.text_byte);
      cls_in.is_colon  = (req_item.text_byte == CH_COLON);
      cls_in.is_slash  = (req_item.text_byte == CH_SLASH);
      cls_in.last      = req_item.last_byte;
      valid_in         = take ? 1'b1 : (valid_ff && !cls_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         cls_ff <= cls_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_item  = cls_ff;

endmodule

### rtl/usf_queue.sv
// Short register queue between the classifier and the scanner.
`timescale 1ns / 1ps
module usf_queue
   import usf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  usf_cls_type push_item,
   output logic        pop_valid,
   input  logic        pop_ready,
   output usf_cls_type pop_item
);

   localparam int unsigned PTR_W = (USF_QDEPTH > 1) ? $clog2(USF_QDEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(USF_QDEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(USF_QDEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(USF_QDEPTH - 1);

   usf_cls_type      slot_ff [USF_QDEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != DEPTH_C);
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### rtl/usf_back.sv
// Back stage: scanner state, separator match and the result register.
`timescale 1ns / 1ps
module usf_back
   import usf_pkg::*;
#(
   parameter longint unsigned MAX_TEXT = USF_MAX_TEXT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cls_valid,
   output logic                cls_ready,
   input  usf_cls_type         cls_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output usf_rsp_type         rsp_item,
   output usf_back_status_type status
);

   localparam longint unsigned LIM_L = (MAX_TEXT < 64'd65535) ? MAX_TEXT : 64'd65535;
   localparam logic [USF_POS_W-1:0] LIM = LIM_L[USF_POS_W-1:0];

   logic [USF_POS_W-1:0] pos_ff, pos_in, run_ff, run_in;
   logic [USF_POS_W-1:0] scheme_ff, scheme_in, cur_ff, cur_in;
   logic                 prev_ff, prev_in, present_ff, present_in;
   logic [1:0]           sep_ff, sep_in;
   logic                 inside_ff, inside_in, sat_ff, sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   usf_rsp_type          rsp_ff, rsp_in;
   logic                 fire, sat_hit, emit;

   assign cls_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = cls_valid && cls_ready;
   assign sat_hit   = (pos_ff >= LIM);

   always_comb begin
      pos_in     = pos_ff;
      run_in     = run_ff;
      scheme_in  = scheme_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      present_in = present_ff;
      sep_in     = sep_ff;
      inside_in  = inside_ff;
      sat_in     = sat_ff;
      emit       = 1'b0;
      rsp_in     = rsp_ff;
      if (fire) begin
         pos_in = sat_hit ? LIM : pos_ff + 1'b1;
         sat_in = sat_ff || sat_hit;
         if (inside_ff) begin
            if (!cls_item.is_url) begin
               emit             = 1'b1;
               rsp_in.url_start = cur_ff;
               rsp_in.url_stop  = pos_ff;
               inside_in        = 1'b0;
               sep_in           = SEP_NONE;
               prev_in          = 1'b0;
            end
         end else if (sep_ff == SEP_FULL && present_ff && cls_item.is_url) begin
            inside_in = 1'b1;
            cur_in    = scheme_ff;
            sep_in    = SEP_NONE;
            prev_in   = 1'b0;
         end else begin
            if (sep_ff == SEP_COLON && cls_item.is_slash) begin
               sep_in = SEP_SLASH;
            end else if (sep_ff == SEP_SLASH && cls_item.is_slash) begin
               sep_in = SEP_FULL;
            end else if (cls_item.is_colon) begin
               sep_in     = SEP_COLON;
               present_in = prev_ff;
               scheme_in  = run_ff;
            end else begin
               sep_in = SEP_NONE;
            end
            if (cls_item.is_letter) begin
               if (!prev_ff) begin
                  run_in = pos_ff;
               end
               prev_in = 1'b1;
            end else begin
               prev_in = 1'b0;
            end
         end
         // End of text closes an open URL one past this byte.
         if (cls_item.last && inside_in) begin
            emit             = 1'b1;
            rsp_in.url_start = cur_in;
            rsp_in.url_stop  = sat_hit ? LIM : pos_ff + 1'b1;
         end
         rsp_in.offsets_saturated = sat_in;
         if (cls_item.last) begin
            pos_in     = '0;
            run_in     = '0;
            scheme_in  = '0;
            cur_in     = '0;
            prev_in    = 1'b0;
            present_in = 1'b0;
            sep_in     = SEP_NONE;
            inside_in  = 1'b0;
            sat_in     = 1'b0;
         end
      end
      rsp_valid_in = fire ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_ff       <= '0;
         scheme_ff    <= '0;
         cur_ff       <= '0;
         prev_ff      <= 1'b0;
         present_ff   <= 1'b0;
         sep_ff       <= SEP_NONE;
         inside_ff    <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         scheme_ff    <= scheme_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         present_ff   <= present_in;
         sep_ff       <= sep_in;
         inside_ff    <= inside_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      status.fire       = fire;
      status.last       = cls_item.last;
      status.inside_url = inside_ff;
      status.sep_stage  = sep_ff;
      status.pos        = pos_ff;
   end

endmodule

### tb/tb_url_span_finder.sv
// Self-checking testbench for the URL span finder: byte stream in, URL spans out.
`timescale 1ns / 1ps
module tb_url_span_finder;
   import usf_pkg::*;

   // Offsets clamp here; the block never counts past 16 bits.
   localparam int unsigned OFFSET_CAP =
      32'((USF_MAX_TEXT < 64'd65535) ? USF_MAX_TEXT : 64'd65535);
   localparam int unsigned IDLE_PCT = 28;

   // One pending text byte; settle asks the sender to wait for all spans first.
   typedef struct {
      usf_req_type item;
      bit          settle;
   } feed_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   usf_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   usf_rsp_type rsp_item;

   feed_entry_type text_feed_q[$];
   usf_rsp_type    url_spans_q[$];
   string          url_punct = "~;/?:@=&$-_.+!*'(),";

   int unsigned bytes_sent = 0;
   int unsigned spans_seen = 0;
   int unsigned err_cnt = 0;
   int unsigned text_len = 0;
   bit          settle_next = 1'b0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   logic        steady;

   // Predicted scanner state.
   int unsigned scan_pos;
   bit          scan_sat;
   logic [15:0] run_from;
   bit          after_letter;
   logic [15:0] scheme_from;
   bit          have_scheme;
   logic [1:0]  sep;
   bit          in_url;
   logic [15:0] url_from;

   url_span_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A stretch with no random idling on either side.
   assign steady = (bytes_sent >= 150) && (bytes_sent < 400);

   // ---------------------------------------------------------------------
   // Byte classes and the scan predictor
   // ---------------------------------------------------------------------
   function automatic bit alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit url_byte(input logic [7:0] c);
      bit hit;
      hit = alpha(c) || (c >= "0" && c <= "9");
      for (int k = 0; k < url_punct.len(); k++)
         if (c == url_punct[k]) hit = 1'b1;
      return hit;
   endfunction

   function automatic void clear_scan();
      scan_pos = 0;
      scan_sat = 1'b0;
      run_from = '0;
      after_letter = 1'b0;
      scheme_from = '0;
      have_scheme = 1'b0;
      sep = SEP_NONE;
      in_url = 1'b0;
      url_from = '0;
   endfunction

   // Advance the predicted scanner by one accepted byte; queue any span it closes.
   function automatic void scan_text_byte(input usf_req_type it);
      logic [7:0]  c;
      int unsigned p;
      bit          hit;
      usf_rsp_type span;
      c = it.text_byte;
      p = scan_pos;
      hit = 1'b0;
      span = '0;
      if (scan_pos >= OFFSET_CAP) begin
         scan_pos = OFFSET_CAP;
         scan_sat = 1'b1;
      end else begin
         scan_pos = p + 1;
      end
      if (in_url) begin
         // Any non-URL byte closes the span just before itself.
         if (!url_byte(c)) begin
            hit = 1'b1;
            span.url_start = url_from;
            span.url_stop = p[15:0];
            in_url = 1'b0;
            sep = SEP_NONE;
            after_letter = 1'b0;
         end
      end else if (sep == SEP_FULL && have_scheme && url_byte(c)) begin
         in_url = 1'b1;
         url_from = scheme_from;
         sep = SEP_NONE;
         after_letter = 1'b0;
      end else begin
         if (sep == SEP_COLON && c == CH_SLASH)
            sep = SEP_SLASH;
         else if (sep == SEP_SLASH && c == CH_SLASH)
            sep = SEP_FULL;
         else if (c == CH_COLON) begin
            sep = SEP_COLON;
            have_scheme = after_letter;
            scheme_from = run_from;
         end else
            sep = SEP_NONE;
         if (alpha(c)) begin
            if (!after_letter) run_from = p[15:0];
            after_letter = 1'b1;
         end else begin
            after_letter = 1'b0;
         end
      end
      // End of text closes an open span after the current byte.
      if (it.last_byte && in_url) begin
         hit = 1'b1;
         span.url_start = url_from;
         span.url_stop = (p >= OFFSET_CAP) ? OFFSET_CAP[15:0] : 16'(p + 1);
         in_url = 1'b0;
      end
      if (hit) begin
         span.offsets_saturated = scan_sat;
         url_spans_q.insert(url_spans_q.size(), span);
      end
      if (it.last_byte) clear_scan();
   endfunction

   // ---------------------------------------------------------------------
   // Text generation
   // ---------------------------------------------------------------------
   function automatic logic [7:0] rand_letter();
      return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_url_char();
      case ($urandom_range(0, 2))
         0: return rand_letter();
         1: return 8'h30 + 8'($urandom_range(0, 9));
         default: return url_punct[$urandom_range(0, url_punct.len() - 1)];
      endcase
   endfunction

   function automatic logic [7:0] rand_stop_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (url_byte(c));
      return c;
   endfunction

   function automatic void add_byte(input logic [7:0] c);
      feed_entry_type e;
      e.item.text_byte = c;
      e.item.last_byte = 1'b0;
      e.settle = settle_next;
      settle_next = 1'b0;
      text_feed_q.insert(text_feed_q.size(), e);
      text_len++;
   endfunction

   function automatic void add_str(input string s);
      for (int k = 0; k < s.len(); k++) add_byte(s[k]);
   endfunction

   // Mark the newest byte as the end of the text.
   function automatic void end_text();
      if (text_len == 0) add_byte(8'($urandom_range(0, 255)));
      text_feed_q[text_feed_q.size() - 1].item.last_byte = 1'b1;
      text_len = 0;
   endfunction

   // Scheme, separator, a body with the odd embedded separator, then maybe a stop.
   function automatic void add_url_chunk();
      int unsigned n;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) add_byte(rand_letter());
      add_str("://");
      n = $urandom_range(0, 10);
      for (int k = 0; k < n; k++)
         if ($urandom_range(0, 9) == 0) add_str("://");
         else add_byte(rand_url_char());
      if ($urandom_range(0, 3) != 0) add_byte(rand_stop_char());
   endfunction

   // Noise or a near-miss separator.
   function automatic void add_junk_chunk();
      int unsigned n;
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 1) != 0) begin
         for (int k = 0; k < n; k++) add_byte(8'($urandom_range(0, 255)));
      end else begin
         for (int k = 0; k < n; k++)
            add_byte(($urandom_range(0, 3) == 0) ? rand_url_char() : rand_letter());
         add_byte(CH_COLON);
         if ($urandom_range(0, 1) != 0) add_byte(CH_SLASH);
         add_byte(($urandom_range(0, 1) != 0) ? rand_stop_char() : rand_url_char());
      end
   endfunction

   function automatic void add_chunk();
      if ($urandom_range(0, 99) < 70) add_url_chunk();
      else add_junk_chunk();
   endfunction

   function automatic void add_text();
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) add_chunk();
      end_text();
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus and reset
   // ---------------------------------------------------------------------
   initial begin
      clear_scan();
      // Directed: end-of-text close, non-URL close on 0xFF, no scheme before
      // the separator, and a separator that ends the text.
      add_str("Ab://x");
      end_text();
      add_str("z://~");
      add_byte(8'hFF);
      add_byte(8'h00);
      end_text();
      add_str("1://a");
      end_text();
      add_str("q://");
      end_text();

      // Random texts, with pauses for the block to drain midway and at the end.
      while (text_feed_q.size() < 780) begin
         if (text_feed_q.size() > 500 && text_feed_q.size() < 520) settle_next = 1'b1;
         add_text();
      end
      settle_next = 1'b1;
      add_text();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver: offer the next byte whenever the slot is free
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            scan_text_byte(req_item);
            bytes_sent++;
         end
         // Hold a pending item until it goes through.
         if (!req_valid || req_ready) begin
            if (text_feed_q.size() == 0 ||
                (text_feed_q[0].settle && url_spans_q.size() != 0) ||
                (!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_item <= text_feed_q[0].item;
               void'(text_feed_q.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each span against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      usf_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            spans_seen++;
            if (url_spans_q.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected span start %0d stop %0d sat %0b", $time,
                        rsp_item.url_start, rsp_item.url_stop,
                        rsp_item.offsets_saturated);
            end else begin
               want = url_spans_q.pop_front();
               if (rsp_item.url_start !== want.url_start ||
                   rsp_item.url_stop !== want.url_stop ||
                   rsp_item.offsets_saturated !== want.offsets_saturated) begin
                  err_cnt++;
                  $display("%0t: span mismatch, expected start %0d stop %0d sat %0b,",
                           $time, want.url_start, want.url_stop,
                           want.offsets_saturated,
                           " actual start %0d stop %0d sat %0b",
                           rsp_item.url_start, rsp_item.url_stop,
                           rsp_item.offsets_saturated);
               end
            end
         end
         // Once, hold off the result side long enough for the input to back up.
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && spans_seen >= 20) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------------
   initial begin
      @(negedge reset);
      @(posedge clock);
      while (text_feed_q.size() != 0 || req_valid) @(posedge clock);
      while (url_spans_q.size() != 0) @(posedge clock);
      // Leave room for a stray span behind the last one.
      repeat (20) @(posedge clock);
      if (err_cnt == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(20_000_000);
      $display("%0t: run timed out", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
